// ===== design/pcre_pkg.sv =====
// ----------------------------------------------------------------------------
// pcre_pkg
// Shared types, register codes and bit helpers of the programmable CRC engine.
// ----------------------------------------------------------------------------
package pcre_pkg;

    // bus commands
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // register select, taken from offset bits 3:2
    localparam logic [1:0] REG_DATA = 2'd0;
    localparam logic [1:0] REG_POLY = 2'd1;
    localparam logic [1:0] REG_CTRL = 2'd2;

    // transpose codes
    localparam logic [1:0] TP_NONE  = 2'd0;
    localparam logic [1:0] TP_BITS  = 2'd1;
    localparam logic [1:0] TP_BOTH  = 2'd2;
    localparam logic [1:0] TP_BYTES = 2'd3;

    // control register fields
    localparam int CTRL_WIDE_BIT = 24;
    localparam int CTRL_SEED_BIT = 25;
    localparam int CTRL_FXOR_BIT = 26;
    localparam logic [31:0] CTRL_MASK = 32'hf700_0000;
    localparam logic [31:0] LOW_HALF  = 32'h0000_ffff;
    localparam logic [31:0] HIGH_HALF = 32'hffff_0000;

    // reset values
    localparam logic [31:0] CRC_RESET  = 32'hffff_ffff;
    localparam logic [31:0] POLY_RESET = 32'h0000_1021;
    localparam logic [31:0] CTRL_RESET = 32'h0000_0000;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FEED = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // reverse the bit order of one byte
    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

    // byte order and bit order change of a 32-bit word
    function automatic logic [31:0] transpose32(input logic [31:0] v, input logic [1:0] mode);
        logic [31:0] o;
        logic [7:0]  b;
        o = '0;
        for (int i = 0; i < 4; i++) begin
            b = v[i*8 +: 8];
            if (mode == TP_BITS || mode == TP_BOTH) begin
                b = rev8(b);
            end
            if (mode == TP_BOTH || mode == TP_BYTES) begin
                o[(3 - i)*8 +: 8] = b;
            end else begin
                o[i*8 +: 8] = b;
            end
        end
        return o;
    endfunction

    // mask of the low count bytes
    function automatic logic [31:0] bytes_mask(input logic [2:0] count);
        logic [31:0] m;
        case (count)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    // place written bytes at their offset inside an old register value
    function automatic logic [31:0] merge_bytes(input logic [31:0] old, input logic [1:0] sub,
                                                input logic [2:0] count, input logic [31:0] wd);
        logic [31:0] m;
        m = bytes_mask(count) << {sub, 3'b000};
        return (old & ~m) | ((wd << {sub, 3'b000}) & m);
    endfunction

endpackage

// ===== design/pcre_crc_unit.sv =====
// ----------------------------------------------------------------------------
// pcre_crc_unit
// One byte of a bitwise msb-first CRC, 16 or 32 bits wide, shared by the
// sequencer for every fed byte.
// ----------------------------------------------------------------------------
module pcre_crc_unit
    import pcre_pkg::*;
(
    input  logic [31:0] i_remainder,
    input  logic [31:0] i_poly,
    input  logic        i_wide,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_remainder
);

    logic [31:0] w_mask;
    logic [31:0] w_c;
    logic        w_top;

    // eight shift and reduce steps
    always_comb begin
        w_mask = i_wide ? 32'hffff_ffff : LOW_HALF;
        w_c    = i_remainder & w_mask;
        if (i_wide) begin
            w_c[31:24] = w_c[31:24] ^ i_byte;
        end else begin
            w_c[15:8] = w_c[15:8] ^ i_byte;
        end
        w_top = 1'b0;
        for (int i = 0; i < 8; i++) begin
            w_top = i_wide ? w_c[31] : w_c[15];
            w_c   = (w_c << 1) & w_mask;
            if (w_top) begin
                w_c = w_c ^ (i_poly & w_mask);
            end
        end
        o_remainder = w_c;
    end

endmodule

// ===== design/programmable_crc_register_engine.sv =====
// Reads, register writes, seed writes and rejected accesses go from IDLE to DONE
// and then to the output register; a fed data write runs FEED for each byte first.
// The shared CRC unit handles one byte per cycle. A new access is taken only in IDLE,
// once the last has left DONE; the output register lets the next access in early.
// Reset (synchronous, active low): remainder all ones, polynomial 0x1021,
// control zero, no result pending.
// ----------------------------------------------------------------------------
// programmable_crc_register_engine
// CRC peripheral with data, polynomial and control registers behind a
// byte-addressed access port, with a byte-serial CRC sequencer.
// ----------------------------------------------------------------------------
module programmable_crc_register_engine
    import pcre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [3:0]  i_register_offset,
    input  logic [2:0]  i_access_bytes,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_data,
    output logic        o_access_ok
);

    t_state      r_state, n_state;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_poly, n_poly;
    logic [31:0] r_ctrl, n_ctrl;
    logic [31:0] r_data, n_data;
    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_left, n_left;
    logic [1:0]  r_idx, n_idx;
    logic [31:0] r_pend_data, n_pend_data;
    logic        r_pend_ok, n_pend_ok;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_data, n_out_data;
    logic        r_out_ok, n_out_ok;

    logic        w_take;
    logic        w_legal;
    logic        w_feed;
    logic [1:0]  w_sub;
    logic [1:0]  w_reg;
    logic [1:0]  w_tw;
    logic        w_wide;
    logic [31:0] w_readout;
    logic [31:0] w_merged;
    logic [1:0]  w_src;
    logic [7:0]  w_byte;
    logic [31:0] w_crc_next;
    logic        w_slot_free;

    assign o_ready     = (r_state == S_IDLE);
    assign w_take      = i_valid && o_ready;
    assign w_sub       = i_register_offset[1:0];
    assign w_reg       = i_register_offset[3:2];
    assign w_tw        = r_ctrl[31:30];
    assign w_wide      = r_ctrl[CTRL_WIDE_BIT];
    assign w_slot_free = !r_out_valid || i_ready;

    // access check: size, offset range, alignment
    assign w_legal = (i_access_bytes == 3'd1 || i_access_bytes == 3'd2
                      || i_access_bytes == 3'd4)
                     && (i_register_offset < 4'd12)
                     && (({2'b00, w_sub} + {1'b0, i_access_bytes}) <= 4'd4);

    assign w_feed = w_legal && (i_command == CMD_WRITE) && (w_reg == REG_DATA)
                    && !r_ctrl[CTRL_SEED_BIT];

    // data read view: complement and read transpose
    always_comb begin
        w_readout = r_crc & (w_wide ? 32'hffff_ffff : LOW_HALF);
        if (r_ctrl[CTRL_FXOR_BIT]) begin
            w_readout = ~w_readout & (w_wide ? 32'hffff_ffff : LOW_HALF);
        end
        w_readout = transpose32(w_readout, r_ctrl[29:28]);
    end

    // polynomial merge of written bytes
    assign w_merged = merge_bytes(r_poly, w_sub, i_access_bytes, i_write_data);

    // byte to feed this cycle
    always_comb begin
        if (w_tw == TP_BOTH || w_tw == TP_BYTES) begin
            w_src = r_idx;
        end else begin
            w_src = r_cnt[1:0] - 2'd1 - r_idx;
        end
        w_byte = 8'(r_data >> {w_src, 3'b000});
        if (w_tw == TP_BITS || w_tw == TP_BOTH) begin
            w_byte = rev8(w_byte);
        end
    end

    pcre_crc_unit u_crc_unit (
        .i_remainder (r_crc),
        .i_poly      (r_poly),
        .i_wide      (w_wide),
        .i_byte      (w_byte),
        .o_remainder (w_crc_next)
    );

    // sequencer and register updates
    always_comb begin
        n_state     = r_state;
        n_crc       = r_crc;
        n_poly      = r_poly;
        n_ctrl      = r_ctrl;
        n_data      = r_data;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_idx       = r_idx;
        n_pend_data = r_pend_data;
        n_pend_ok   = r_pend_ok;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_ok    = r_out_ok;

        // output register drains on a transfer
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_pend_data = '0;
                    n_pend_ok   = w_legal;
                    n_state     = S_DONE;
                    if (w_legal) begin
                        if (i_command == CMD_READ) begin
                            unique case (w_reg)
                                REG_DATA: n_pend_data = (w_readout >> {w_sub, 3'b000})
                                                        & bytes_mask(i_access_bytes);
                                REG_POLY: n_pend_data = r_poly >> {w_sub, 3'b000};
                                default:  n_pend_data = r_ctrl >> {w_sub, 3'b000};
                            endcase
                        end else begin
                            unique case (w_reg)
                                REG_DATA: begin
                                    if (r_ctrl[CTRL_SEED_BIT]) begin
                                        n_crc = transpose32((i_write_data
                                                & bytes_mask(i_access_bytes))
                                                << {w_sub, 3'b000}, w_tw);
                                    end else begin
                                        n_data  = i_write_data;
                                        n_cnt   = i_access_bytes;
                                        n_left  = i_access_bytes;
                                        n_idx   = '0;
                                        n_state = S_FEED;
                                    end
                                end
                                REG_POLY: begin
                                    n_poly = w_wide ? w_merged
                                             : ((r_poly & HIGH_HALF) | (w_merged & LOW_HALF));
                                end
                                default: begin
                                    n_ctrl = merge_bytes(r_ctrl, w_sub, i_access_bytes,
                                                         i_write_data) & CTRL_MASK;
                                end
                            endcase
                        end
                    end
                end
            end
            S_FEED: begin
                n_crc  = w_crc_next;
                n_idx  = r_idx + 2'd1;
                n_left = r_left - 3'd1;
                if (r_left == 3'd1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_pend_data;
                    n_out_ok    = r_pend_ok;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_crc       <= CRC_RESET;
            r_poly      <= POLY_RESET;
            r_ctrl      <= CTRL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_crc       <= n_crc;
            r_poly      <= n_poly;
            r_ctrl      <= n_ctrl;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_data      <= n_data;
        r_cnt       <= n_cnt;
        r_left      <= n_left;
        r_idx       <= n_idx;
        r_pend_data <= n_pend_data;
        r_pend_ok   <= n_pend_ok;
        r_out_data  <= n_out_data;
        r_out_ok    <= n_out_ok;
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_access_ok = r_out_ok;

`ifndef NO_ASSERTIONS
    // feeding never runs with no bytes left
    a_feed_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FEED |-> r_left != 3'd0)
        else $error("feed state with no bytes left");

    // reserved control bits stay clear
    a_ctrl_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctrl & ~CTRL_MASK) == 32'h0)
        else $error("reserved control bits set");

    // a fed data write enters the byte loop
    a_feed_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && w_feed |=> r_state == S_FEED && r_left == $past(i_access_bytes))
        else $error("fed write did not start the byte loop");

    // a finished result moves out as soon as the output slot is free
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && w_slot_free |=> r_out_valid && r_state == S_IDLE)
        else $error("finished result not moved to output");
`endif

endmodule

// ===== dv/tb_programmable_crc_register_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_programmable_crc_register_engine
// Self-checking bench for the CRC register engine. A short list of directed
// accesses comes first: reset values, rejected sizes and offsets, seed and
// feed writes, masked control writes and the 16-bit polynomial write. A long
// run of random accesses follows, most of them well formed. Every result is
// compared with its typed-in value or else a local model of the three registers
// and the CRC datapath. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_programmable_crc_register_engine;
    import pcre_pkg::*;

    localparam int          RANDOM_ACCESSES = 2000;
    localparam int          MAX_REPORTS     = 10;
    localparam logic [3:0]  OFFSET_LIMIT    = 4'd12;
    localparam int          DIRECTED_ROWS   = 27;

    // one access result as seen on the output port
    typedef struct packed {
        logic [31:0] read_data;
        logic        access_ok;
    } t_access_result;

    // one directed access, with an optional typed-in result
    typedef struct packed {
        logic        cmd;
        logic [3:0]  offset;
        logic [2:0]  count;
        logic [31:0] wdata;
        logic        fixed_result;
        logic [31:0] rdata;
        logic        ok;
    } t_access_row;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_valid           = 1'b0;
    logic        o_ready;
    logic        i_command         = CMD_READ;
    logic [3:0]  i_register_offset = 4'd0;
    logic [2:0]  i_access_bytes    = 3'd1;
    logic [31:0] i_write_data      = 32'd0;
    logic        o_valid;
    logic        i_ready           = 1'b0;
    logic [31:0] o_read_data;
    logic        o_access_ok;

    // model state of the register file
    logic [31:0] model_crc  = CRC_RESET;
    logic [31:0] poly_value = POLY_RESET;
    logic [31:0] ctrl_value = CTRL_RESET;

    t_access_result pending_results[$];
    int             mismatch_count = 0;
    bit             calm_phase     = 1'b0;

    t_access_row directed_rows [DIRECTED_ROWS] = '{
        '{CMD_READ,  4'd0,  3'd4, 32'h0000_0000, 1'b1, 32'h0000_ffff, 1'b1},
        '{CMD_READ,  4'd4,  3'd4, 32'h0000_0000, 1'b1, 32'h0000_1021, 1'b1},
        '{CMD_READ,  4'd8,  3'd4, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{CMD_READ,  4'd3,  3'd2, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_WRITE, 4'd12, 3'd1, 32'hffff_ffff, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_READ,  4'd15, 3'd1, 32'hffff_ffff, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_WRITE, 4'd0,  3'd3, 32'h0012_3456, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_WRITE, 4'd0,  3'd0, 32'h0000_00aa, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_READ,  4'd4,  3'd7, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_WRITE, 4'd1,  3'd4, 32'h1111_1111, 1'b1, 32'h0000_0000, 1'b0},
        '{CMD_WRITE, 4'd0,  3'd1, 32'h0000_00a5, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_WRITE, 4'd2,  3'd2, 32'h0000_5a3c, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_READ,  4'd1,  3'd1, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_WRITE, 4'd8,  3'd4, 32'hffff_ffff, 1'b1, 32'h0000_0000, 1'b1},
        '{CMD_READ,  4'd8,  3'd4, 32'h0000_0000, 1'b1, 32'hf700_0000, 1'b1},
        '{CMD_WRITE, 4'd1,  3'd2, 32'h0000_beef, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_READ,  4'd0,  3'd4, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_WRITE, 4'd4,  3'd4, 32'h04c1_1db7, 1'b1, 32'h0000_0000, 1'b1},
        '{CMD_READ,  4'd6,  3'd2, 32'h0000_0000, 1'b1, 32'h0000_04c1, 1'b1},
        '{CMD_WRITE, 4'd11, 3'd1, 32'h0000_0045, 1'b1, 32'h0000_0000, 1'b1},
        '{CMD_WRITE, 4'd0,  3'd4, 32'hffff_ffff, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_READ,  4'd2,  3'd2, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_WRITE, 4'd8,  3'd4, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{CMD_WRITE, 4'd4,  3'd2, 32'h0000_8005, 1'b1, 32'h0000_0000, 1'b1},
        '{CMD_READ,  4'd4,  3'd4, 32'h0000_0000, 1'b1, 32'h04c1_8005, 1'b1},
        '{CMD_WRITE, 4'd0,  3'd4, 32'h1234_5678, 1'b0, 32'h0000_0000, 1'b0},
        '{CMD_READ,  4'd0,  3'd2, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0}
    };

    programmable_crc_register_engine i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_command         (i_command),
        .i_register_offset (i_register_offset),
        .i_access_bytes    (i_access_bytes),
        .i_write_data      (i_write_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_read_data       (o_read_data),
        .o_access_ok       (o_access_ok)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("programmable_crc_register_engine: mismatch");
        $finish;
    end

    // mirror a byte
    function automatic logic [7:0] flip_byte(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

    // byte swap and/or per-byte bit mirror of a word
    function automatic logic [31:0] reorder_word(input logic [31:0] v, input logic [1:0] mode);
        logic [31:0] o;
        logic [7:0]  b;
        o = '0;
        for (int i = 0; i < 4; i++) begin
            b = v[i*8 +: 8];
            if (mode == TP_BITS || mode == TP_BOTH) begin
                b = flip_byte(b);
            end
            if (mode == TP_BOTH || mode == TP_BYTES) begin
                o[(3 - i)*8 +: 8] = b;
            end else begin
                o[i*8 +: 8] = b;
            end
        end
        return o;
    endfunction

    function automatic logic [31:0] lane_mask(input logic [2:0] count);
        return (count >= 3'd4) ? 32'hffff_ffff : ((32'd1 << (count * 8)) - 32'd1);
    endfunction

    function automatic logic [31:0] splice_bytes(input logic [31:0] old, input logic [1:0] sub,
                                                 input logic [2:0] count,
                                                 input logic [31:0] wd);
        logic [31:0] m;
        m = lane_mask(count) << (sub * 8);
        return (old & ~m) | ((wd << (sub * 8)) & m);
    endfunction

    // one byte through the msb-first crc at the current width
    function automatic void crc_shift_byte(input logic [7:0] b);
        logic        wide;
        int          w;
        logic [31:0] m;
        logic [31:0] c;
        logic        top;
        wide = ctrl_value[CTRL_WIDE_BIT];
        w    = wide ? 32 : 16;
        m    = wide ? 32'hffff_ffff : LOW_HALF;
        c    = model_crc & m;
        c    = c ^ ({24'd0, b} << (w - 8));
        for (int i = 0; i < 8; i++) begin
            top = c[w - 1];
            c   = (c << 1) & m;
            if (top) begin
                c = c ^ (poly_value & m);
            end
        end
        model_crc = c;
    endfunction

    // remainder as seen by a data read
    function automatic logic [31:0] crc_read_value();
        logic [31:0] m;
        logic [31:0] c;
        m = ctrl_value[CTRL_WIDE_BIT] ? 32'hffff_ffff : LOW_HALF;
        c = model_crc & m;
        if (ctrl_value[CTRL_FXOR_BIT]) begin
            c = ~c & m;
        end
        return reorder_word(c, ctrl_value[29:28]);
    endfunction

    // result of one access, updating the register model
    function automatic t_access_result apply_access(input logic cmd, input logic [3:0] offset,
                                                    input logic [2:0] count,
                                                    input logic [31:0] wd);
        t_access_result res;
        logic [1:0]     sub;
        logic [1:0]     wr_mode;
        logic [31:0]    p;
        logic [7:0]     b;
        int             src;
        res     = '0;
        sub     = offset[1:0];
        wr_mode = ctrl_value[31:30];
        if (!(count == 3'd1 || count == 3'd2 || count == 3'd4) || offset >= OFFSET_LIMIT ||
            sub + count > 4) begin
            return res;
        end
        res.access_ok = 1'b1;
        case (offset[3:2])
            REG_DATA: begin
                if (cmd == CMD_READ) begin
                    res.read_data = (crc_read_value() >> (sub * 8)) & lane_mask(count);
                end else if (ctrl_value[CTRL_SEED_BIT]) begin
                    model_crc = reorder_word((wd & lane_mask(count)) << (sub * 8), wr_mode);
                end else begin
                    // bytes go in msb first unless the byte order is swapped
                    for (int i = 0; i < count; i++) begin
                        src = (wr_mode == TP_BOTH || wr_mode == TP_BYTES) ? i : count - 1 - i;
                        b   = wd[src*8 +: 8];
                        if (wr_mode == TP_BITS || wr_mode == TP_BOTH) begin
                            b = flip_byte(b);
                        end
                        crc_shift_byte(b);
                    end
                end
            end
            REG_POLY: begin
                if (cmd == CMD_READ) begin
                    res.read_data = poly_value >> (sub * 8);
                end else begin
                    p = splice_bytes(poly_value, sub, count, wd);
                    poly_value = ctrl_value[CTRL_WIDE_BIT] ? p :
                                 ((poly_value & HIGH_HALF) | (p & LOW_HALF));
                end
            end
            default: begin
                if (cmd == CMD_READ) begin
                    res.read_data = ctrl_value >> (sub * 8);
                end else begin
                    ctrl_value = splice_bytes(ctrl_value, sub, count, wd) & CTRL_MASK;
                end
            end
        endcase
        return res;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // present one access and wait for its transfer; entered and left at a falling edge
    task automatic send_access(input logic cmd, input logic [3:0] offset,
                               input logic [2:0] count, input logic [31:0] wd,
                               input logic fixed_result, input t_access_result fixed);
        t_access_result predicted;
        while (!calm_phase && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_command         <= cmd;
        i_register_offset <= offset;
        i_access_bytes    <= count;
        i_write_data      <= wd;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        predicted = apply_access(cmd, offset, count, wd);
        pending_results.push_back(fixed_result ? fixed : predicted);
        @(negedge i_clk);
    endtask

    // hold the sender until every pending result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // random access, mostly well formed, some pure noise
    task automatic make_random_access(output logic cmd, output logic [3:0] offset,
                                      output logic [2:0] count, output logic [31:0] wd);
        int          pick;
        logic [1:0]  reg_sel;
        logic [1:0]  sub;
        wd   = $urandom;
        cmd  = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 12) begin
            offset = 4'($urandom_range(15));
            count  = 3'($urandom_range(7));
        end else begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                reg_sel = REG_DATA;
                cmd     = ($urandom_range(99) < 60) ? CMD_WRITE : CMD_READ;
            end else if (pick < 75) begin
                reg_sel = REG_POLY;
            end else begin
                reg_sel = REG_CTRL;
            end
            case ($urandom_range(2))
                0:       count = 3'd1;
                1:       count = 3'd2;
                default: count = 3'd4;
            endcase
            sub    = 2'($urandom_range(4 - count));
            offset = {reg_sel, sub};
        end
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        i_ready <= calm_phase || ($urandom_range(99) >= 21);
    end

    // result checker
    always @(posedge i_clk) begin : check_results
        t_access_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result data=%08h ok=%0b",
                                       o_read_data, o_access_ok));
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    note_failure($sformatf("read_data expected %08h got %08h",
                                           want.read_data, o_read_data));
                end
                if (o_access_ok !== want.access_ok) begin
                    note_failure($sformatf("access_ok expected %0b got %0b",
                                           want.access_ok, o_access_ok));
                end
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        t_access_result fixed;
        logic           cmd;
        logic [3:0]     offset;
        logic [2:0]     count;
        logic [31:0]    wd;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed accesses
        foreach (directed_rows[n]) begin
            fixed.read_data = directed_rows[n].rdata;
            fixed.access_ok = directed_rows[n].ok;
            send_access(directed_rows[n].cmd, directed_rows[n].offset, directed_rows[n].count,
                        directed_rows[n].wdata, directed_rows[n].fixed_result, fixed);
        end
        drain_results();

        // random accesses, with a stretch in which neither handshake side idles
        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            calm_phase = (n >= 900 && n < 1300);
            if (n == 1500) begin
                drain_results();
            end
            make_random_access(cmd, offset, count, wd);
            send_access(cmd, offset, count, wd, 1'b0, '0);
        end
        calm_phase = 1'b0;

        drain_results();
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("programmable_crc_register_engine: match");
        end else begin
            $display("programmable_crc_register_engine: mismatch");
        end
        $finish;
    end

endmodule
